// File: rtl/akf_pkg.sv
// Package for the angle Kalman filter: widths, register map, reset values, sequencer states, saturation.
package akf_pkg;
  localparam int DataFracBits = 16;
  localparam int CoefFracBits = 24;
  localparam int AddrW = 4;

  localparam logic [AddrW-1:0] RegQa = 4'h0;
  localparam logic [AddrW-1:0] RegQg = 4'h4;
  localparam logic [AddrW-1:0] RegR  = 4'h8;
  localparam logic [AddrW-1:0] RegDt = 4'hC;

  localparam logic [31:0] QaReset = 32'd16777;
  localparam logic [31:0] QgReset = 32'd50332;
  localparam logic [31:0] RReset  = 32'd8388608;
  localparam logic [31:0] DtReset = 32'd167772;

  typedef enum logic [4:0] {
    S_IDLE, S_R, S_ANG, S_D0, S_P00, S_P01, S_P10, S_P11, S_E,
    S_DIV0, S_DIV1, S_C00, S_C01, S_C10, S_C11, S_CANG, S_CBIAS, S_OUT, S_HOLD
  } akf_state_t;

  // multiply request to the shared unit
  typedef struct packed {
    logic signed [33:0] a;
    logic signed [33:0] b;
  } akf_mul_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction
endpackage

// File: rtl/akf_mul.sv
// Shared multiplier with half-up rounding and arithmetic right shift.
module akf_mul #(
  parameter int COEF_FRAC_BITS = akf_pkg::CoefFracBits
) (
  input  logic                      clk,
  input  akf_pkg::akf_mul_req_t     req,
  output logic signed [65:0]        prod_r
);
  import akf_pkg::*;
  logic signed [67:0] full;
  localparam logic signed [67:0] Half = 68'sd1 <<< (COEF_FRAC_BITS - 1);
  assign full = req.a * req.b;
  always_ff @(posedge clk) begin
    prod_r <= 66'((full + Half) >>> COEF_FRAC_BITS);
  end
endmodule

// File: rtl/akf_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
module akf_div #(
  parameter int COEF_FRAC_BITS = akf_pkg::CoefFracBits
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [33:0] den,
  output logic               done,
  output logic signed [31:0] quot
);
  import akf_pkg::*;
  localparam int NW = 32 + COEF_FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] n_r, n_nxt, q_r, q_nxt;
  logic [NW:0]   rem_r, rem_nxt, trial;
  logic [33:0]   d_r, d_nxt;
  logic          neg_r, neg_nxt, busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] qs;
  logic [NW:0]   sh;
  always_comb begin
    n_nxt = n_r; q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r;
    neg_nxt = neg_r; busy_nxt = busy_r; cnt_nxt = cnt_r;
    sh = {rem_r[NW-1:0], n_r[NW-1]};
    trial = sh - (NW+1)'(d_r);
    qs = {q_r[NW-2:0], ~trial[NW]};
    if (start) begin
      n_nxt = (num[31] ? NW'(-{{(NW-32){1'b1}}, num}) : NW'({{(NW-32){1'b0}}, num}))
              << COEF_FRAC_BITS;
      d_nxt = den[33] ? 34'(-den) : den;
      neg_nxt = num[31] ^ den[33];
      rem_nxt = '0; q_nxt = '0; busy_nxt = 1'b1; cnt_nxt = CW'(NW);
    end else if (busy_r) begin
      n_nxt = n_r << 1;
      if (!trial[NW]) begin
        rem_nxt = trial;
      end else begin
        rem_nxt = sh;
      end
      q_nxt = qs;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt; q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt;
  end
  assign done = busy_r && (cnt_r == CW'(1));
  always_comb begin
    if (neg_r) quot = sat32(-66'($signed({2'b00, qs})));
    else       quot = sat32(66'($signed({2'b00, qs})));
  end
endmodule

// File: rtl/angle_kalman_filter.sv
// Top level of the two-state angle / gyro-bias Kalman filter.
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | tdata[31:0] accel_angle, [63:32] gyro_rate
// out     | out | out_tvalid/tready  | tdata[31:0] angle_estimate_out, [63:32] corrected_rate
// cfg     | in  | APB psel/penable   | 4 x 32-bit registers at 0x0..0xC
// Each sample makes 11 passes through the shared multiplier and two divisions
// of 56 quotient bits each; no new sample is taken until the result is out.
// With a zero gain denominator the divisions are skipped.
// in_tready is high only while idle; out_tvalid holds until out_tready.
// rst_n is synchronous; state returns to zero angle, zero bias, identity P.
module angle_kalman_filter #(
  parameter int COEF_FRAC_BITS = akf_pkg::CoefFracBits
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [63:0]             in_tdata,   // accel_angle, gyro_rate
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [63:0]             out_tdata,  // angle_estimate_out, corrected_rate
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [akf_pkg::AddrW-1:0] cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import akf_pkg::*;
  localparam logic signed [31:0] One = 32'sd1 <<< COEF_FRAC_BITS;

  akf_state_t st_r, st_nxt;
  logic [31:0] qa_r, qg_r, rn_r, dt_r;
  logic signed [31:0] acc_r, gyr_r, ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [31:0] r_r, d0_r, k0_r, k1_r, t0_r, t1_r;
  logic signed [32:0] err_r;
  logic signed [33:0] e_r;
  logic [63:0] out_r;
  akf_mul_req_t mreq;
  logic signed [65:0] prod;
  logic div_start, div_done;
  logic signed [31:0] div_num, quot;
  logic wr;

  akf_mul #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mul (.clk(clk), .req(mreq), .prod_r(prod));
  akf_div #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(e_r),
    .done(div_done), .quot(quot));

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    unique case (cfg_paddr)
      RegQa:   cfg_prdata = qa_r;
      RegQg:   cfg_prdata = qg_r;
      RegR:    cfg_prdata = rn_r;
      RegDt:   cfg_prdata = dt_r;
      default: cfg_prdata = '0;
    endcase
  end

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_HOLD);
  assign out_tdata = out_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (in_tvalid) st_nxt = S_R;
      S_R:     st_nxt = S_ANG;
      S_ANG:   st_nxt = S_D0;
      S_D0:    st_nxt = S_P00;
      S_P00:   st_nxt = S_P01;
      S_P01:   st_nxt = S_P10;
      S_P10:   st_nxt = S_P11;
      S_P11:   st_nxt = S_E;
      S_E:     st_nxt = (e_r == 34'sd0) ? S_C00 : S_DIV0;
      S_DIV0:  if (div_done) st_nxt = S_DIV1;
      S_DIV1:  if (div_done) st_nxt = S_C00;
      S_C00:   st_nxt = S_C01;
      S_C01:   st_nxt = S_C10;
      S_C10:   st_nxt = S_C11;
      S_C11:   st_nxt = S_CANG;
      S_CANG:  st_nxt = S_CBIAS;
      S_CBIAS: st_nxt = S_OUT;
      S_OUT:   st_nxt = S_HOLD;
      S_HOLD:  if (out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // multiplier operands and divider start: each multiplying state issues one product, consumed next state
  always_comb begin
    mreq.a = '0; mreq.b = '0;
    div_start = 1'b0; div_num = p00_r;
    unique case (st_r)
      S_R:     begin mreq.a = 34'(r_r);  mreq.b = 34'($signed({2'b00, dt_r})); end
      S_D0:    begin mreq.a = 34'(d0_r); mreq.b = 34'($signed({2'b00, dt_r})); end
      S_P00, S_P01: begin
                     mreq.a = 34'(p11_r); mreq.b = 34'($signed({2'b00, dt_r})); end
      S_P10:   begin mreq.a = 34'($signed({2'b00, qg_r}));
                     mreq.b = 34'($signed({2'b00, dt_r})); end
      S_E:     div_start = (e_r != 34'sd0);
      S_DIV0:  begin div_num = p10_r; div_start = div_done; end
      S_C00:   begin mreq.a = 34'(k0_r); mreq.b = 34'(t0_r); end
      S_C01:   begin mreq.a = 34'(k0_r); mreq.b = 34'(t1_r); end
      S_C10:   begin mreq.a = 34'(k1_r); mreq.b = 34'(t0_r); end
      S_C11:   begin mreq.a = 34'(k1_r); mreq.b = 34'(t1_r); end
      S_CANG:  begin mreq.a = 34'(k0_r); mreq.b = 34'(err_r); end
      S_CBIAS: begin mreq.a = 34'(k1_r); mreq.b = 34'(err_r); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      qa_r <= QaReset; qg_r <= QgReset; rn_r <= RReset; dt_r <= DtReset;
      ang_r <= '0; bias_r <= '0;
      p00_r <= One; p01_r <= '0; p10_r <= '0; p11_r <= One;
    end else begin
      st_r <= st_nxt;
      if (wr) begin
        case (cfg_paddr)
          RegQa: qa_r <= cfg_pwdata;
          RegQg: qg_r <= cfg_pwdata;
          RegR:  rn_r <= cfg_pwdata;
          RegDt: dt_r <= cfg_pwdata;
          default: ;
        endcase
      end
      unique case (st_r)
        S_IDLE: if (in_tvalid) begin
          acc_r <= in_tdata[31:0]; gyr_r <= in_tdata[63:32];
          r_r <= sat32(66'($signed(in_tdata[63:32])) - 66'(bias_r));
        end
        S_R:   ;
        S_ANG: begin
          ang_r <= sat32(66'(ang_r) + prod);
          d0_r <= sat32($signed({34'd0, qa_r}) - 66'(p01_r) - 66'(p10_r));
        end
        S_D0:  ;
        S_P00: p00_r <= sat32(66'(p00_r) + prod);
        S_P01: p01_r <= sat32(66'(p01_r) - prod);
        S_P10: p10_r <= sat32(66'(p10_r) - prod);
        S_P11: begin
          p11_r <= sat32(66'(p11_r) + prod);
          err_r <= 33'(acc_r) - 33'(ang_r);
          e_r <= $signed({2'b00, rn_r}) + 34'(p00_r);
          k0_r <= '0; k1_r <= '0;
        end
        S_E:    begin t0_r <= p00_r; t1_r <= p01_r; end
        S_DIV0: if (div_done) k0_r <= quot;
        S_DIV1: if (div_done) k1_r <= quot;
        S_C01:  p00_r <= sat32(66'(p00_r) - prod);
        S_C10:  p01_r <= sat32(66'(p01_r) - prod);
        S_C11:  p10_r <= sat32(66'(p10_r) - prod);
        S_CANG: p11_r <= sat32(66'(p11_r) - prod);
        S_CBIAS: ang_r <= sat32(66'(ang_r) + prod);
        S_OUT: begin
          bias_r <= sat32(66'(bias_r) + prod);
        end
        S_HOLD: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_OUT) out_r <= {sat32(66'(gyr_r) - 66'(sat32(66'(bias_r) + prod))), ang_r};
  end

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (st_r == S_R)) else $error("accept lost");
  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_E && e_r == 34'sd0) |=> (st_r == S_C00 && k0_r == 32'sd0))
    else $error("zero denominator gain");
endmodule
